FILE: src/epbc_pkg.sv
package epbc_pkg;

  localparam int MEMORY_BYTES = 2048;
  localparam int PAGE_BYTES   = 32;
  localparam int MEM_AW       = $clog2(MEMORY_BYTES);
  localparam int SLOT_W       = $clog2(PAGE_BYTES);
  localparam int PAGE_W       = MEM_AW - SLOT_W;
  localparam int ADDR_W       = 11;
  localparam int CMD_W        = 3;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ        = 3'd0,
    CMD_LOAD        = 3'd1,
    CMD_FLUSH       = 3'd2,
    CMD_ERASE_WRITE = 3'd3,
    CMD_ERASE_PAGE  = 3'd4,
    CMD_SPLIT_WRITE = 3'd5,
    CMD_ERASE_ALL   = 3'd6
  } cmd_t;

  typedef struct packed {
    logic              load;
    logic              flush;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
  } buf_ctl_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       marked;
    logic       any_loaded;
  } buf_sts_t;

endpackage

FILE: src/epbc_mem.sv
module epbc_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [epbc_pkg::MEM_AW-1:0] wa,
  input  logic [7:0]                wd,
  input  logic                      re,
  input  logic [epbc_pkg::MEM_AW-1:0] ra,
  output logic [7:0]                rdata
);

  logic [7:0] mem [epbc_pkg::MEMORY_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[ra];
    end
  end

endmodule

FILE: src/epbc_buf.sv
module epbc_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  epbc_pkg::buf_ctl_t ctl,
  output epbc_pkg::buf_sts_t sts
);

  logic [7:0]                     buf_mem [epbc_pkg::PAGE_BYTES];
  logic [epbc_pkg::PAGE_BYTES-1:0] marks_r;
  logic [epbc_pkg::PAGE_BYTES-1:0] marks_nxt;

  // payload, no reset: unmarked slots are never used
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      buf_mem[ctl.slot] <= marks_r[ctl.slot] ? (buf_mem[ctl.slot] & ctl.data) : ctl.data;
    end
  end

  always_comb begin
    marks_nxt = marks_r;
    if (ctl.flush) begin
      marks_nxt = '0;
    end else if (ctl.load) begin
      marks_nxt[ctl.slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else begin
      marks_r <= marks_nxt;
    end
  end

  assign sts.rdata      = buf_mem[ctl.slot];
  assign sts.marked     = marks_r[ctl.slot];
  assign sts.any_loaded = |marks_r;

endmodule

FILE: src/eeprom_page_buffer_controller.sv
// EEPROM controller with a one-page write buffer.
// Input channel: in_cmd, in_byte_address, in_write_byte with in_valid/in_stall.
// Result channel: out_read_byte, out_buffer_loaded with out_valid/out_stall.
// One request is worked at a time; exactly one result per request.
// Work from acceptance to result valid, by command:
//   load, flush, unused code : straight to the finish state
//   read                     : RAM read, captured in ST_RDW, then finish
//   erase-write, erase page,
//   split write              : one slot per cycle through
//                              a read/write pipeline on the array RAM
//   erase all                : a sweep of every byte, one byte per cycle
// A new request is taken only once the last one has left the finish state.
// After reset the array RAM is swept to 0xFF; in_stall stays high until the
// sweep is done. Buffer marks clear at once.
// The result sits in an output register; a stalled result holds and the
// next request is still taken and worked, waiting only for that register.
module eeprom_page_buffer_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [epbc_pkg::CMD_W-1:0]  in_cmd,
  input  logic [epbc_pkg::ADDR_W-1:0] in_byte_address,
  input  logic [7:0]                  in_write_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_read_byte,
  output logic                        out_buffer_loaded
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDW,
    ST_PAGE,
    ST_FIN
  } state_t;

  state_t                            state_r, state_nxt;
  logic [epbc_pkg::MEM_AW-1:0]       all_cnt_r, all_cnt_nxt;
  logic                              sweep_res_r, sweep_res_nxt;
  logic [epbc_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [epbc_pkg::PAGE_W-1:0]       page_r, page_nxt;
  logic [epbc_pkg::SLOT_W-1:0]       cnt_r, cnt_nxt;
  logic                              issue_r, issue_nxt;
  logic                              wr_v_r, wr_v_nxt;
  logic [epbc_pkg::SLOT_W-1:0]       wr_slot_r, wr_slot_nxt;
  logic [7:0]                        res_rd_r, res_rd_nxt;
  logic                              res_ld_r, res_ld_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [7:0]                        out_rd_r, out_rd_nxt;
  logic                              out_ld_r, out_ld_nxt;

  logic                              accept;
  logic [epbc_pkg::MEM_AW-1:0]       in_addr;
  logic                              mem_we, mem_re;
  logic [epbc_pkg::MEM_AW-1:0]       mem_wa, mem_ra;
  logic [7:0]                        mem_wd, mem_rdata;
  epbc_pkg::buf_ctl_t                bctl;
  epbc_pkg::buf_sts_t                bsts;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_addr  = epbc_pkg::MEM_AW'(in_byte_address);

  epbc_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .wa    (mem_wa),
    .wd    (mem_wd),
    .re    (mem_re),
    .ra    (mem_ra),
    .rdata (mem_rdata)
  );

  epbc_buf u_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bctl),
    .sts   (bsts)
  );

  always_comb begin
    state_nxt     = state_r;
    all_cnt_nxt   = all_cnt_r;
    sweep_res_nxt = sweep_res_r;
    cmd_nxt       = cmd_r;
    page_nxt      = page_r;
    cnt_nxt       = cnt_r;
    issue_nxt     = issue_r;
    wr_v_nxt      = 1'b0;
    wr_slot_nxt   = wr_slot_r;
    res_rd_nxt    = res_rd_r;
    res_ld_nxt    = res_ld_r;
    mem_we        = 1'b0;
    mem_wa        = all_cnt_r;
    mem_wd        = epbc_pkg::ERASED_BYTE;
    mem_re        = 1'b0;
    mem_ra        = in_addr;
    bctl.load     = 1'b0;
    bctl.flush    = 1'b0;
    bctl.slot     = epbc_pkg::SLOT_W'(in_byte_address);
    bctl.data     = in_write_byte;

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        all_cnt_nxt = all_cnt_r + 1'b1;
        if (&all_cnt_r) begin
          res_rd_nxt = 8'h00;
          res_ld_nxt = 1'b0;
          state_nxt  = sweep_res_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          page_nxt   = in_addr[epbc_pkg::MEM_AW-1:epbc_pkg::SLOT_W];
          res_rd_nxt = 8'h00;
          res_ld_nxt = bsts.any_loaded;
          state_nxt  = ST_FIN;
          case (in_cmd)
            epbc_pkg::CMD_READ: begin
              mem_re    = 1'b1;
              state_nxt = ST_RDW;
            end
            epbc_pkg::CMD_LOAD: begin
              bctl.load  = 1'b1;
              res_ld_nxt = 1'b1;
            end
            epbc_pkg::CMD_FLUSH: begin
              bctl.flush = 1'b1;
              res_ld_nxt = 1'b0;
            end
            epbc_pkg::CMD_ERASE_WRITE,
            epbc_pkg::CMD_ERASE_PAGE,
            epbc_pkg::CMD_SPLIT_WRITE: begin
              cnt_nxt   = '0;
              issue_nxt = 1'b1;
              state_nxt = ST_PAGE;
            end
            epbc_pkg::CMD_ERASE_ALL: begin
              bctl.flush    = 1'b1;
              all_cnt_nxt   = '0;
              sweep_res_nxt = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDW: begin
        res_rd_nxt = mem_rdata;
        state_nxt  = ST_FIN;
      end
      ST_PAGE: begin
        bctl.slot = wr_slot_r;
        mem_ra    = {page_r, cnt_r};
        mem_wa    = {page_r, wr_slot_r};
        if (issue_r) begin
          mem_re      = 1'b1;
          wr_v_nxt    = 1'b1;
          wr_slot_nxt = cnt_r;
          cnt_nxt     = cnt_r + 1'b1;
          if (&cnt_r) begin
            issue_nxt = 1'b0;
          end
        end
        if (wr_v_r) begin
          case (cmd_r)
            epbc_pkg::CMD_ERASE_WRITE: begin
              mem_we = bsts.marked;
              mem_wd = bsts.rdata;
            end
            epbc_pkg::CMD_SPLIT_WRITE: begin
              mem_we = bsts.marked;
              mem_wd = mem_rdata & bsts.rdata;
            end
            default: begin
              mem_we = 1'b1;
              mem_wd = epbc_pkg::ERASED_BYTE;
            end
          endcase
          if (!issue_r) begin
            bctl.flush = 1'b1;
            res_rd_nxt = 8'h00;
            res_ld_nxt = 1'b0;
            state_nxt  = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_rd_nxt    = out_rd_r;
    out_ld_nxt    = out_ld_r;
    if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = res_rd_r;
      out_ld_nxt    = res_ld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      all_cnt_r   <= '0;
      sweep_res_r <= 1'b0;
      issue_r     <= 1'b0;
      wr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      all_cnt_r   <= all_cnt_nxt;
      sweep_res_r <= sweep_res_nxt;
      issue_r     <= issue_nxt;
      wr_v_r      <= wr_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    page_r    <= page_nxt;
    cnt_r     <= cnt_nxt;
    wr_slot_r <= wr_slot_nxt;
    res_rd_r  <= res_rd_nxt;
    res_ld_r  <= res_ld_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ld_r  <= out_ld_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_byte     = out_rd_r;
  assign out_buffer_loaded = out_ld_r;

  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken during the reset sweep");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_wa != mem_ra)
    else $error("array read and write to one byte in one cycle");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish state");

endmodule

FILE: test/tb_eeprom_page_buffer_controller.sv
`timescale 1ns / 100ps

module tb_eeprom_page_buffer_controller;

  localparam logic [epbc_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int PAGE_COUNT     = epbc_pkg::MEMORY_BYTES / epbc_pkg::PAGE_BYTES;
  localparam int RANDOM_REQS    = 500;
  localparam int MAX_GAP        = 14;
  localparam int WATCHDOG_LIMIT = 5 * (epbc_pkg::MEMORY_BYTES + 64);
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [epbc_pkg::CMD_W-1:0]  cmd;
    logic [epbc_pkg::ADDR_W-1:0] addr;
    logic [7:0]                  wdata;
    int                          gap;
  } request_t;

  typedef struct {
    logic [7:0] read_byte;
    logic       loaded;
  } reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [epbc_pkg::CMD_W-1:0]  in_cmd = '0;
  logic [epbc_pkg::ADDR_W-1:0] in_byte_address = '0;
  logic [7:0]                  in_write_byte = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  out_read_byte;
  logic                        out_buffer_loaded;

  request_t cmd_queue[$];
  reply_t   reply_queue[$];
  request_t next_req;
  logic     staged = 1'b0;

  logic [7:0]                      mem_image [epbc_pkg::MEMORY_BYTES];
  logic [7:0]                      page_buf [epbc_pkg::PAGE_BYTES];
  logic [epbc_pkg::PAGE_BYTES-1:0] slot_marks;

  int errors = 0;
  int results_seen = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  eeprom_page_buffer_controller u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_byte_address   (in_byte_address),
    .in_write_byte     (in_write_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_byte     (out_read_byte),
    .out_buffer_loaded (out_buffer_loaded)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_page_buf();
    foreach (page_buf[k]) page_buf[k] = epbc_pkg::ERASED_BYTE;
    slot_marks = '0;
  endfunction

  function automatic reply_t apply_command(logic [epbc_pkg::CMD_W-1:0] cmd,
                                           logic [epbc_pkg::ADDR_W-1:0] addr,
                                           logic [7:0] wdata);
    int unsigned a, slot, base, idx;
    reply_t r;
    a    = addr % epbc_pkg::MEMORY_BYTES;
    slot = a % epbc_pkg::PAGE_BYTES;
    base = a - slot;
    r.read_byte = '0;
    case (cmd)
      epbc_pkg::CMD_READ: r.read_byte = mem_image[a];
      epbc_pkg::CMD_LOAD: begin
        page_buf[slot]   = page_buf[slot] & wdata;
        slot_marks[slot] = 1'b1;
      end
      epbc_pkg::CMD_FLUSH: clear_page_buf();
      epbc_pkg::CMD_ERASE_WRITE: begin
        for (int k = 0; k < epbc_pkg::PAGE_BYTES; k++) begin
          idx = (base + k) % epbc_pkg::MEMORY_BYTES;
          if (slot_marks[k]) mem_image[idx] = page_buf[k];
        end
        clear_page_buf();
      end
      epbc_pkg::CMD_ERASE_PAGE: begin
        for (int k = 0; k < epbc_pkg::PAGE_BYTES; k++) begin
          idx = (base + k) % epbc_pkg::MEMORY_BYTES;
          mem_image[idx] = epbc_pkg::ERASED_BYTE;
        end
        clear_page_buf();
      end
      epbc_pkg::CMD_SPLIT_WRITE: begin
        for (int k = 0; k < epbc_pkg::PAGE_BYTES; k++) begin
          idx = (base + k) % epbc_pkg::MEMORY_BYTES;
          if (slot_marks[k]) mem_image[idx] = mem_image[idx] & page_buf[k];
        end
        clear_page_buf();
      end
      epbc_pkg::CMD_ERASE_ALL: begin
        foreach (mem_image[k]) mem_image[k] = epbc_pkg::ERASED_BYTE;
        clear_page_buf();
      end
      default: ;
    endcase
    r.loaded = |slot_marks;
    return r;
  endfunction

  function automatic void add_req(logic [epbc_pkg::CMD_W-1:0] cmd, int unsigned addr,
                                  int unsigned wdata);
    request_t q;
    q.cmd   = cmd;
    q.addr  = addr[epbc_pkg::ADDR_W-1:0];
    q.wdata = wdata[7:0];
    // every third stretch of forty requests runs back to back
    q.gap   = ((cmd_queue.size() / 40) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
    cmd_queue.push_back(q);
  endfunction

  task automatic flag(string text);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", text);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) reply_queue.push_back(apply_command(in_cmd, in_byte_address, in_write_byte));
      if (!staged && cmd_queue.size() > 0) begin
        next_req = cmd_queue.pop_front();
        staged   = 1'b1;
      end
      if (staged && next_req.gap == 0) begin
        in_cmd          <= next_req.cmd;
        in_byte_address <= next_req.addr;
        in_write_byte   <= next_req.wdata;
        in_valid        <= 1'b1;
        staged = 1'b0;
      end else begin
        if (staged) next_req.gap--;
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    int     nstall;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          flag($sformatf("unexpected result: read_byte=%02h buffer_loaded=%0b",
                         out_read_byte, out_buffer_loaded));
        end else begin
          want = reply_queue.pop_front();
          if (out_read_byte !== want.read_byte)
            flag($sformatf("result %0d read_byte: expected %02h, got %02h",
                           results_seen, want.read_byte, out_read_byte));
          if (out_buffer_loaded !== want.loaded)
            flag($sformatf("result %0d buffer_loaded: expected %0b, got %0b",
                           results_seen, want.loaded, out_buffer_loaded));
        end
        results_seen++;
        nstall = ((results_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        nstall = (stall_left > 0) ? stall_left - 1 : 0;
      end
      stall_left <= nstall;
      out_stall  <= (nstall != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned                hot_pages [4];
    int unsigned                page, kind;
    logic [epbc_pkg::CMD_W-1:0] cmd;
    int                         target;

    foreach (mem_image[k]) mem_image[k] = epbc_pkg::ERASED_BYTE;
    clear_page_buf();

    // directed: field extremes, AND on reload, unused code, empty commits, page at array end
    add_req(epbc_pkg::CMD_READ, 0, 0);
    add_req(epbc_pkg::CMD_READ, epbc_pkg::MEMORY_BYTES - 1, 'hFF);
    add_req(epbc_pkg::CMD_LOAD, 'h000, 'hAA);
    add_req(epbc_pkg::CMD_LOAD, 'h020, 'h0F);
    add_req(epbc_pkg::CMD_LOAD, 'h01F, 'h00);
    add_req(epbc_pkg::CMD_LOAD, 'h7FF, 'hFF);
    add_req(CMD_UNUSED, 'h155, 'h33);
    add_req(epbc_pkg::CMD_ERASE_WRITE, 'h005, 'h00);
    add_req(epbc_pkg::CMD_READ, 'h000, 0);
    add_req(epbc_pkg::CMD_READ, 'h01F, 0);
    add_req(epbc_pkg::CMD_READ, 'h001, 0);
    add_req(epbc_pkg::CMD_LOAD, 'h7E0, 'h5A);
    add_req(epbc_pkg::CMD_LOAD, 'h7E1, 'h00);
    add_req(epbc_pkg::CMD_SPLIT_WRITE, 'h7FF, 'hFF);
    add_req(epbc_pkg::CMD_READ, 'h7E0, 0);
    add_req(epbc_pkg::CMD_LOAD, 'h003, 'hF0);
    add_req(epbc_pkg::CMD_SPLIT_WRITE, 'h000, 0);
    add_req(epbc_pkg::CMD_SPLIT_WRITE, 'h400, 0);
    add_req(epbc_pkg::CMD_LOAD, 'h010, 'h3C);
    add_req(epbc_pkg::CMD_FLUSH, 'h7FF, 'h00);
    add_req(epbc_pkg::CMD_ERASE_WRITE, 'h010, 0);
    add_req(epbc_pkg::CMD_ERASE_PAGE, 'h000, 0);
    add_req(epbc_pkg::CMD_READ, 'h000, 0);
    add_req(epbc_pkg::CMD_LOAD, 'h2AA, 'h55);
    add_req(epbc_pkg::CMD_ERASE_ALL, 'h555, 'hAA);
    add_req(epbc_pkg::CMD_READ, 'h7E0, 0);

    hot_pages[0] = 0;
    hot_pages[1] = PAGE_COUNT - 1;
    hot_pages[2] = $urandom_range(1, PAGE_COUNT - 2);
    hot_pages[3] = $urandom_range(1, PAGE_COUNT - 2);

    target = cmd_queue.size() + RANDOM_REQS;
    while (cmd_queue.size() < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // load a few slots, commit to a page (or flush), read it back
        page = ($urandom_range(0, 3) != 0) ? hot_pages[$urandom_range(0, 3)]
                                           : $urandom_range(0, PAGE_COUNT - 1);
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 4) == 0)
            add_req(epbc_pkg::CMD_LOAD, $urandom, $urandom);
          else
            add_req(epbc_pkg::CMD_LOAD,
                    page * epbc_pkg::PAGE_BYTES + $urandom_range(0, epbc_pkg::PAGE_BYTES - 1),
                    $urandom);
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: cmd = epbc_pkg::CMD_ERASE_WRITE;
          5, 6, 7:       cmd = epbc_pkg::CMD_SPLIT_WRITE;
          8:             cmd = epbc_pkg::CMD_FLUSH;
          default:       cmd = epbc_pkg::CMD_ERASE_PAGE;
        endcase
        add_req(cmd, page * epbc_pkg::PAGE_BYTES + $urandom_range(0, epbc_pkg::PAGE_BYTES - 1),
                $urandom);
        repeat ($urandom_range(1, 4))
          add_req(epbc_pkg::CMD_READ,
                  page * epbc_pkg::PAGE_BYTES + $urandom_range(0, epbc_pkg::PAGE_BYTES - 1),
                  $urandom);
      end else if (kind < 9) begin
        cmd = epbc_pkg::CMD_W'($urandom_range(0, 7));
        // keep full-array erases rare, they sweep the whole array
        if (cmd == epbc_pkg::CMD_ERASE_ALL && $urandom_range(0, 3) != 0) cmd = epbc_pkg::CMD_READ;
        add_req(cmd, $urandom, $urandom);
      end else begin
        add_req(($urandom_range(0, 1) != 0) ? epbc_pkg::CMD_ERASE_PAGE : epbc_pkg::CMD_READ,
                $urandom, $urandom);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() > 0 || staged || in_valid || reply_queue.size() > 0)
      @(negedge clk);
    repeat (epbc_pkg::PAGE_BYTES + 8) @(negedge clk);

    if (errors == 0 && reply_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
